[rtl/ibs_pkg.sv]
// Package with shared constants, types and codes for the inference batch scheduler.
package ibs_pkg;

  localparam int WAIT_DEPTH = 64;
  localparam int RUN_DEPTH  = 32;
  localparam int MAX_RESULTS = 32;
  localparam int WAW = $clog2(WAIT_DEPTH);
  localparam int RAW = $clog2(RUN_DEPTH);
  localparam int NREGS = 6;
  localparam int PAW = 5;

  typedef enum logic [1:0] {
    OP_ENQ_WAIT = 2'd0,
    OP_ENQ_RUN  = 2'd1,
    OP_STEP     = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RK_ACK      = 2'd0,
    RK_SELECT   = 2'd1,
    RK_NOTHING  = 2'd2,
    RK_UNUSED   = 2'd3
  } result_kind_t;

  localparam logic [2:0] KIND_EMBED = 3'd4;

  localparam logic [1:0] POL_CONT    = 2'd0;
  localparam logic [1:0] POL_REQUEST = 2'd1;
  localparam logic [1:0] POL_SINGLE  = 2'd2;

  localparam logic [2:0] REG_POLICY      = 3'd0;
  localparam logic [2:0] REG_MAX_RUNNING = 3'd1;
  localparam logic [2:0] REG_EMBED_MIX   = 3'd2;
  localparam logic [2:0] REG_MAX_EMBED   = 3'd3;
  localparam logic [2:0] REG_PREFILL_1ST = 3'd4;
  localparam logic [2:0] REG_MAX_TOKENS  = 3'd5;

  typedef struct packed {
    logic [15:0] tok;
    logic [2:0]  kind;
    logic [7:0]  id;
  } rec_t;

  typedef struct packed {
    logic [1:0]  adm_policy;
    logic [5:0]  max_running;
    logic        embed_with_prefill;
    logic [5:0]  max_embed_images;
    logic        prefill_first;
    logic [15:0] max_fill_tokens;
  } cfg_t;

endpackage

[rtl/inference_batch_scheduler.sv]
// Top level of the inference batch scheduler: queues, step sequencer and result port.
//
// Requests are taken when start is high and busy is low. An enqueue (to the waiting
// FIFO or to the running list) does not raise busy, and its acknowledge appears on
// the result port in the next cycle. A step request keeps busy high while a small
// sequencer works through the running list with one read port: each admitted record
// is read in S_ADM_RD and written in S_ADM_WR, then the list is walked four times
// (other/empty stages, embed stages, and the two fill groups) with an S_RD and an
// S_PROC state per record, and S_FIN gives the final result. Results appear one per
// cycle at most, each for exactly one cycle under result_valid, and cannot be held
// off by the receiver; last marks the final result of a request. Records that are
// not selected are copied into the other half of a double-banked running store, so
// their order within each pass is kept without a separate copy pass. Configuration
// registers may be written only while busy is low and no result is still due.
module inference_batch_scheduler (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              opcode,
  input  logic [7:0]              seq_id,
  input  logic [2:0]              stage_kind,
  input  logic [15:0]             token_count,
  output logic                    result_valid,
  output logic [1:0]              result_kind,
  output logic [7:0]              out_seq_id,
  output logic [2:0]              out_stage_kind,
  output logic                    dropped,
  output logic                    last,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ibs_pkg::PAW-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import ibs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ADM_RD = 6'b000010,
    S_ADM_WR = 6'b000100,
    S_RD     = 6'b001000,
    S_PROC   = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  cfg_t cfg;

  ibs_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  state_t state;

  // Waiting FIFO.
  rec_t           wait_mem [WAIT_DEPTH];
  rec_t           wait_rd;
  logic [WAW-1:0] wait_head;
  logic [WAW:0]   wait_count;

  // Running list, two banks; cur_bank holds the live list.
  rec_t           run_mem [2*RUN_DEPTH];
  rec_t           run_rd;
  logic           cur_bank;
  logic [RAW:0]   run_count;
  logic           run_we;
  logic [RAW:0]   run_waddr;
  rec_t           run_wdata;

  // Step bookkeeping.
  logic [RAW:0]   idx;
  logic [1:0]     pass;
  logic [RAW:0]   keep_count;
  logic [5:0]     nres;
  logic [5:0]     imgs;
  logic [15:0]    spent;
  logic           has_pre;
  logic           adm_en;
  logic           pend_valid;
  logic [7:0]     pend_id;
  logic [2:0]     pend_kind;

  rec_t           in_rec;
  logic           accept;
  logic [RAW:0]   limit;
  logic           adm_go;
  logic           is_fill;
  logic           is_pre;
  logic           want_pre;
  logic           match;
  logic           sel;
  logic [16:0]    spent_sum;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign in_rec = '{tok: token_count, kind: stage_kind, id: seq_id};

  assign limit = (cfg.max_running > 6'(RUN_DEPTH)) ? (RAW+1)'(RUN_DEPTH)
                                                   : (RAW+1)'(cfg.max_running);
  assign adm_go = adm_en && (wait_count != '0) &&
                  ((cfg.adm_policy == POL_SINGLE) || (run_count < limit));

  // Classification of the record read back from the running list.
  assign is_fill  = (run_rd.kind >= 3'd1) && (run_rd.kind <= 3'd3);
  assign is_pre   = is_fill && (run_rd.tok != 16'd1);
  assign want_pre = (pass == 2'd2) == cfg.prefill_first;
  assign spent_sum = {1'b0, spent} + {1'b0, run_rd.tok};

  always_comb begin
    match = 1'b0;
    sel   = 1'b0;
    case (pass)
      2'd0: begin
        match = !is_fill && (run_rd.kind != KIND_EMBED);
        sel   = nres < 6'(MAX_RESULTS);
      end
      2'd1: begin
        match = (run_rd.kind == KIND_EMBED);
        sel   = !(has_pre && !cfg.embed_with_prefill) &&
                (imgs < cfg.max_embed_images) && (nres < 6'(MAX_RESULTS));
      end
      default: begin
        match = is_fill && (is_pre == want_pre);
        sel   = (spent < cfg.max_fill_tokens) && (nres < 6'(MAX_RESULTS));
      end
    endcase
  end

  // Running store write port: enqueue, admission, or keep into the other bank.
  always_comb begin
    run_we    = 1'b0;
    run_waddr = {cur_bank, run_count[RAW-1:0]};
    run_wdata = in_rec;
    if (accept && (opcode == OP_ENQ_RUN) && (run_count != (RAW+1)'(RUN_DEPTH))) begin
      run_we = 1'b1;
    end else if (state == S_ADM_WR) begin
      run_we    = 1'b1;
      run_wdata = wait_rd;
    end else if ((state == S_PROC) && match && !sel) begin
      run_we    = 1'b1;
      run_waddr = {!cur_bank, keep_count[RAW-1:0]};
      run_wdata = run_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    run_rd <= run_mem[{cur_bank, idx[RAW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_ENQ_WAIT) && (wait_count != (WAW+1)'(WAIT_DEPTH))) begin
      wait_mem[wait_head + wait_count[WAW-1:0]] <= in_rec;
    end
    wait_rd <= wait_mem[wait_head];
  end

  // Sequencer and result port.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      wait_head    <= '0;
      wait_count   <= '0;
      run_count    <= '0;
      cur_bank     <= 1'b0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
      idx          <= '0;
      pass         <= '0;
      keep_count   <= '0;
      nres         <= '0;
      imgs         <= '0;
      spent        <= '0;
      has_pre      <= 1'b0;
      adm_en       <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_ENQ_WAIT: begin
                result_valid   <= 1'b1;
                result_kind    <= RK_ACK;
                out_seq_id     <= seq_id;
                out_stage_kind <= stage_kind;
                last           <= 1'b1;
                if (wait_count == (WAW+1)'(WAIT_DEPTH)) begin
                  dropped <= 1'b1;
                end else begin
                  dropped    <= 1'b0;
                  wait_count <= wait_count + 1'b1;
                end
              end
              OP_ENQ_RUN: begin
                result_valid   <= 1'b1;
                result_kind    <= RK_ACK;
                out_seq_id     <= seq_id;
                out_stage_kind <= stage_kind;
                last           <= 1'b1;
                if (run_count == (RAW+1)'(RUN_DEPTH)) begin
                  dropped <= 1'b1;
                end else begin
                  dropped   <= 1'b0;
                  run_count <= run_count + 1'b1;
                end
              end
              OP_STEP: begin
                adm_en <= (cfg.adm_policy == POL_CONT) ||
                          (((cfg.adm_policy == POL_REQUEST) ||
                            (cfg.adm_policy == POL_SINGLE)) && (run_count == '0));
                idx        <= '0;
                pass       <= '0;
                keep_count <= '0;
                nres       <= '0;
                imgs       <= '0;
                spent      <= '0;
                has_pre    <= 1'b0;
                pend_valid <= 1'b0;
                state      <= S_ADM_RD;
              end
              default: ;
            endcase
          end
        end
        S_ADM_RD: begin
          // The head record is read this cycle and, if it is admitted, written next cycle.
          state <= adm_go ? S_ADM_WR : S_RD;
        end
        S_ADM_WR: begin
          run_count  <= run_count + 1'b1;
          wait_head  <= wait_head + 1'b1;
          wait_count <= wait_count - 1'b1;
          if (cfg.adm_policy == POL_SINGLE) begin
            adm_en <= 1'b0;
          end
          state <= S_ADM_RD;
        end
        S_RD: begin
          if (idx == run_count) begin
            idx <= '0;
            if (pass == 2'd3) begin
              state <= S_FIN;
            end else begin
              pass <= pass + 1'b1;
            end
          end else begin
            state <= S_PROC;
          end
        end
        S_PROC: begin
          if ((pass == 2'd0) && is_pre) begin
            has_pre <= 1'b1;
          end
          if (match) begin
            if (sel) begin
              if (pend_valid) begin
                result_valid   <= 1'b1;
                result_kind    <= RK_SELECT;
                out_seq_id     <= pend_id;
                out_stage_kind <= pend_kind;
                dropped        <= 1'b0;
                last           <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_id    <= run_rd.id;
              pend_kind  <= run_rd.kind;
              nres       <= nres + 1'b1;
              if (pass == 2'd1) begin
                imgs <= imgs + 1'b1;
              end
            end else begin
              keep_count <= keep_count + 1'b1;
            end
            if (pass[1]) begin
              spent <= spent_sum[16] ? 16'hFFFF : spent_sum[15:0];
            end
          end
          idx   <= idx + 1'b1;
          state <= S_RD;
        end
        S_FIN: begin
          result_valid <= 1'b1;
          dropped      <= 1'b0;
          last         <= 1'b1;
          if (pend_valid) begin
            result_kind    <= RK_SELECT;
            out_seq_id     <= pend_id;
            out_stage_kind <= pend_kind;
          end else begin
            result_kind    <= RK_NOTHING;
            out_seq_id     <= 8'd0;
            out_stage_kind <= 3'd0;
          end
          pend_valid <= 1'b0;
          run_count  <= keep_count;
          cur_bank   <= !cur_bank;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/ibs_cfg.sv]
// Configuration register bank with its APB-style access port.
module ibs_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ibs_pkg::PAW-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output ibs_pkg::cfg_t        cfg
);
  import ibs_pkg::*;

  logic [2:0] reg_index;

  assign reg_index = paddr[PAW-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adm_policy         <= POL_CONT;
      cfg.max_running        <= 6'd8;
      cfg.embed_with_prefill <= 1'b0;
      cfg.max_embed_images   <= 6'd4;
      cfg.prefill_first      <= 1'b1;
      cfg.max_fill_tokens    <= 16'd2048;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_POLICY:      cfg.adm_policy         <= pwdata[1:0];
        REG_MAX_RUNNING: cfg.max_running        <= pwdata[5:0];
        REG_EMBED_MIX:   cfg.embed_with_prefill <= pwdata[0];
        REG_MAX_EMBED:   cfg.max_embed_images   <= pwdata[5:0];
        REG_PREFILL_1ST: cfg.prefill_first      <= pwdata[0];
        REG_MAX_TOKENS:  cfg.max_fill_tokens    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (reg_index)
      REG_POLICY:      prdata = {30'd0, cfg.adm_policy};
      REG_MAX_RUNNING: prdata = {26'd0, cfg.max_running};
      REG_EMBED_MIX:   prdata = {31'd0, cfg.embed_with_prefill};
      REG_MAX_EMBED:   prdata = {26'd0, cfg.max_embed_images};
      REG_PREFILL_1ST: prdata = {31'd0, cfg.prefill_first};
      REG_MAX_TOKENS:  prdata = {16'd0, cfg.max_fill_tokens};
      default:         prdata = 32'd0;
    endcase
  end

endmodule
